// ===== hdl/itpt_pkg.sv =====
// Package for the indexed task priority table: widths, codes and the types
// shared by the cell row and the top level. No dependencies.
`default_nettype none

package itpt_pkg;

   localparam int TASK_SLOTS = 64;
   localparam int ID_W       = 20;
   localparam int PRIO_W     = 31;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int OP_W       = 2;

   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EDIT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EXEC   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd4;

   localparam logic [OP_W-1:0] OP_NOP    = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [ID_W-1:0]   user_id;
      logic [PRIO_W-1:0] prio;
   } data_type;

   typedef struct packed {
      logic     valid;
      data_type data;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0]   task_id;
      logic [PRIO_W-1:0] prio;
   } key_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      entry_type       entry;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/indexed_task_priority_table.sv =====
// An accepted item gets a compare pass, then an update pass over the cell row;
// its result is registered in the update pass once the result register is free.
// Edit runs both passes twice. A new item is stalled until the last result loads.
// Reset: synchronous; clears every cell's valid bit, so the table is empty at once.
// Top level of the indexed task priority table; uses itpt_pkg and itpt_cell.
`default_nettype none

module indexed_task_priority_table (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [itpt_pkg::KIND_W-1:0]         req_kind,
   input  wire  [itpt_pkg::ID_W-1:0]           req_task_id,
   input  wire  [itpt_pkg::ID_W-1:0]           req_user_id,
   input  wire  [itpt_pkg::PRIO_W-1:0]         req_priority_req,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [itpt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [itpt_pkg::ID_W-1:0]           rsp_top_user_id,
   output logic [itpt_pkg::ID_W-1:0]           rsp_top_task_id
);
   import itpt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_APPLY  = 2'd1;
   localparam logic [1:0] S_RECMP  = 2'd2;
   localparam logic [1:0] S_INSERT = 2'd3;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [KIND_W-1:0]   kind_ff;
   logic [ID_W-1:0]     task_ff;
   logic [ID_W-1:0]     user_ff;
   logic [PRIO_W-1:0]   prio_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     top_user_ff;
   logic [ID_W-1:0]     top_task_ff;
   logic [STATUS_W-1:0] status_in;
   logic [ID_W-1:0]     top_user_in;
   logic [ID_W-1:0]     top_task_in;
   logic                rsp_load;

   logic                accept;
   logic                out_free;
   logic                cmp_en;
   key_type             cmp_key;
   cmd_type             cmd;
   logic                pop;

   entry_type            cell_entry [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] above_vec;
   logic [TASK_SLOTS-1:0] match_vec;
   logic [TASK_SLOTS-1:0] at_or_after;
   logic [TASK_SLOTS-1:0] shift_vec;
   logic                  any_match;
   logic                  full;
   logic                  empty;
   logic [ID_W-1:0]       match_user;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmp_en    = accept || (state_ff == S_RECMP);

   always_comb begin
      if (state_ff == S_IDLE) begin
         cmp_key = '{task_id: req_task_id, prio: req_priority_req};
      end else begin
         cmp_key = '{task_id: task_ff, prio: prio_ff};
      end
   end

   // Task ids are unique, so at most one cell matches; this marks it and all below it.
   assign at_or_after = ~(match_vec - {{(TASK_SLOTS-1){1'b0}}, 1'b1});
   assign any_match   = |match_vec;
   assign full        = cell_entry[TASK_SLOTS-1].valid;
   assign empty       = !cell_entry[0].valid;
   assign shift_vec   = pop ? {TASK_SLOTS{1'b1}} : at_or_after;

   always_comb begin
      match_user = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (match_vec[i]) begin
            match_user = match_user | cell_entry[i].data.user_id;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.op      = OP_NOP;
      cmd.entry   = '{valid: 1'b1,
                      data: '{task_id: task_ff, user_id: user_ff, prio: prio_ff}};
      pop         = 1'b0;
      rsp_load    = 1'b0;
      status_in   = STAT_OK;
      top_user_in = '0;
      top_task_in = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               state_in = S_IDLE;
               rsp_load = 1'b1;
               case (kind_ff)
                  KIND_ADD: begin
                     if (any_match) begin
                        status_in = STAT_DUPLICATE;
                     end else if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  KIND_EDIT: begin
                     if (!any_match) begin
                        status_in = STAT_NOT_FOUND;
                     end else begin
                        cmd.op   = OP_REMOVE;
                        rsp_load = 1'b0;
                        state_in = S_RECMP;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!any_match) begin
                        status_in = STAT_NOT_FOUND;
                     end else begin
                        cmd.op = OP_REMOVE;
                     end
                  end
                  KIND_EXEC: begin
                     if (empty) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        cmd.op      = OP_REMOVE;
                        pop         = 1'b1;
                        top_user_in = cell_entry[0].data.user_id;
                        top_task_in = cell_entry[0].data.task_id;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_RECMP: begin
            state_in = S_INSERT;
         end
         S_INSERT: begin
            if (out_free) begin
               cmd.op   = OP_INSERT;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // An edited task keeps its own user, so the reinsert takes it from the matching cell.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         task_ff <= req_task_id;
         user_ff <= req_user_id;
         prio_ff <= req_priority_req;
      end else if (state_ff == S_APPLY && kind_ff == KIND_EDIT && any_match) begin
         user_ff <= match_user;
      end
      if (rsp_load) begin
         status_ff   <= status_in;
         top_user_ff <= top_user_in;
         top_task_ff <= top_task_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_top_user_id = top_user_ff;
   assign rsp_top_task_id = top_task_ff;

   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_above;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_above = 1'b0;
      end else begin : g_mid_left
         assign left_entry = cell_entry[i-1];
         assign left_above = above_vec[i-1];
      end

      if (i == TASK_SLOTS - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_right
         assign right_entry = cell_entry[i+1];
      end

      itpt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmp_en      (cmp_en),
         .cmp_key     (cmp_key),
         .cmd         (cmd),
         .shift_en    (shift_vec[i]),
         .left_entry  (left_entry),
         .left_above  (left_above),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .above       (above_vec[i]),
         .match       (match_vec[i])
      );
   end

endmodule

`default_nettype wire

// ===== hdl/itpt_cell.sv =====
// One cell of the sorted task row: holds one entry and its compare flags.
// Depends on itpt_pkg for the entry, key and command types.
`default_nettype none

module itpt_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      cmp_en,
   input  wire itpt_pkg::key_type   cmp_key,
   input  wire itpt_pkg::cmd_type   cmd,
   input  wire                      shift_en,
   input  wire itpt_pkg::entry_type left_entry,
   input  wire                      left_above,
   input  wire itpt_pkg::entry_type right_entry,
   output itpt_pkg::entry_type      entry,
   output logic                     above,
   output logic                     match
);
   import itpt_pkg::*;

   logic      valid_ff;
   data_type  data_ff;
   entry_type entry_in;
   logic      above_ff;
   logic      above_in;
   logic      match_ff;
   logic      match_in;

   always_comb begin
      entry_in = {valid_ff, data_ff};
      case (cmd.op)
         OP_INSERT: begin
            if (left_above) begin
               entry_in = left_entry;
            end else if (above_ff) begin
               entry_in = cmd.entry;
            end
         end
         OP_REMOVE: begin
            if (shift_en) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = {valid_ff, data_ff};
         end
      endcase
   end

   always_comb begin
      above_in = above_ff;
      match_in = match_ff;
      if (cmp_en) begin
         match_in = valid_ff && (data_ff.task_id == cmp_key.task_id);
         above_in = !valid_ff ||
                    ({cmp_key.prio, cmp_key.task_id} > {data_ff.prio, data_ff.task_id});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         above_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
         above_ff <= above_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= entry_in.data;
   end

   assign entry = {valid_ff, data_ff};
   assign above = above_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// ===== test/task_table_checker.sv =====
// Checker for the indexed task priority table: watches the request and result
// channels, keeps its own copy of the task table and compares every result.
// Depends on itpt_pkg for widths and codes.
`default_nettype none

module task_table_checker (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_stall,
   input  wire  [itpt_pkg::KIND_W-1:0]   req_kind,
   input  wire  [itpt_pkg::ID_W-1:0]     req_task_id,
   input  wire  [itpt_pkg::ID_W-1:0]     req_user_id,
   input  wire  [itpt_pkg::PRIO_W-1:0]   req_priority_req,
   input  wire                           rsp_valid,
   input  wire                           rsp_stall,
   input  wire  [itpt_pkg::STATUS_W-1:0] rsp_status,
   input  wire  [itpt_pkg::ID_W-1:0]     rsp_top_user_id,
   input  wire  [itpt_pkg::ID_W-1:0]     rsp_top_task_id,
   output int                            failures,
   output int                            outstanding,
   output int                            checked,
   output int                            full_seen,
   output int                            empty_seen
);

   import itpt_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     user_id;
      logic [ID_W-1:0]     task_id;
   } reply_type;

   logic              held      [TASK_SLOTS];
   logic [ID_W-1:0]   held_task [TASK_SLOTS];
   logic [ID_W-1:0]   held_user [TASK_SLOTS];
   logic [PRIO_W-1:0] held_prio [TASK_SLOTS];
   int                held_count;
   reply_type         expected_replies[$];

   function automatic int find_task(input logic [ID_W-1:0] id);
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (held[i] && held_task[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic logic outranks(input int a, input int b);
      if (held_prio[a] != held_prio[b]) return held_prio[a] > held_prio[b];
      return held_task[a] > held_task[b];
   endfunction

   // Applies one item to the table copy and returns the result it must produce.
   function automatic reply_type apply_item(input logic [KIND_W-1:0] kind,
                                            input logic [ID_W-1:0]   id,
                                            input logic [ID_W-1:0]   user,
                                            input logic [PRIO_W-1:0] prio);
      reply_type r;
      int        hit;
      int        slot;
      r   = '{status: STAT_OK, user_id: '0, task_id: '0};
      hit = find_task(id);
      slot = -1;
      case (kind)
         KIND_ADD: begin
            if (hit >= 0) r.status = STAT_DUPLICATE;
            else if (held_count >= TASK_SLOTS) r.status = STAT_FULL;
            else begin
               for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
                  if (!held[i]) slot = i;
               end
               held[slot]      = 1'b1;
               held_task[slot] = id;
               held_user[slot] = user;
               held_prio[slot] = prio;
               held_count++;
            end
         end
         KIND_EDIT: begin
            if (hit < 0) r.status = STAT_NOT_FOUND;
            else held_prio[hit] = prio;
         end
         KIND_REMOVE: begin
            if (hit < 0) r.status = STAT_NOT_FOUND;
            else begin
               held[hit] = 1'b0;
               held_count--;
            end
         end
         default: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (held[i] && (slot < 0 || outranks(i, slot))) slot = i;
            end
            if (slot < 0) r.status = STAT_EMPTY;
            else begin
               r.user_id  = held_user[slot];
               r.task_id  = held_task[slot];
               held[slot] = 1'b0;
               held_count--;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      reply_type want;
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) held[i] = 1'b0;
         held_count = 0;
         expected_replies.delete();
         outstanding = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("result item arrived with no item outstanding");
               failures++;
            end else begin
               want = expected_replies.pop_front();
               checked++;
               if (want.status == STAT_FULL) full_seen++;
               if (want.status == STAT_EMPTY) empty_seen++;
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_top_user_id !== want.user_id) begin
                  $error("top_user_id expected %0h actual %0h", want.user_id,
                         rsp_top_user_id);
                  failures++;
               end
               if (rsp_top_task_id !== want.task_id) begin
                  $error("top_task_id expected %0h actual %0h", want.task_id,
                         rsp_top_task_id);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_item(req_kind, req_task_id, req_user_id,
                                                  req_priority_req));
         end
         outstanding = expected_replies.size();
      end
   end

endmodule

`default_nettype wire

// ===== test/indexed_task_priority_table_tb.sv =====
// Top of the testbench for the indexed task priority table: clock, reset,
// stimulus and verdict. Depends on itpt_pkg, the block and task_table_checker.
`default_nettype none

module indexed_task_priority_table_tb;

   import itpt_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind;
   logic [ID_W-1:0]     req_task_id;
   logic [ID_W-1:0]     req_user_id;
   logic [PRIO_W-1:0]   req_priority_req;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_top_user_id;
   logic [ID_W-1:0]     rsp_top_task_id;

   int                  failures;
   int                  outstanding;
   int                  checked;
   int                  full_seen;
   int                  empty_seen;
   int                  items_sent;
   logic                calm;
   logic [ID_W-1:0]     known_ids[$];

   indexed_task_priority_table DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_task_id      (req_task_id),
      .req_user_id      (req_user_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_top_user_id  (rsp_top_user_id),
      .rsp_top_task_id  (rsp_top_task_id)
   );

   task_table_checker table_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_task_id      (req_task_id),
      .req_user_id      (req_user_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_top_user_id  (rsp_top_user_id),
      .rsp_top_task_id  (rsp_top_task_id),
      .failures         (failures),
      .outstanding      (outstanding),
      .checked          (checked),
      .full_seen        (full_seen),
      .empty_seen       (empty_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic logic [ID_W-1:0] wide_id();
      return ID_W'($urandom_range(0, 20'hFFFFF));
   endfunction

   function automatic logic [ID_W-1:0] small_id();
      return ID_W'($urandom_range(0, 99));
   endfunction

   function automatic logic [ID_W-1:0] known_id();
      if (known_ids.size() == 0) return small_id();
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   function automatic logic [ID_W-1:0] target_id();
      if ($urandom_range(0, 3) == 0) return small_id();
      return known_id();
   endfunction

   // Narrow priorities force ties, so the task id decides the order.
   function automatic logic [PRIO_W-1:0] pick_prio();
      case ($urandom_range(0, 2))
         0:       return PRIO_W'($urandom_range(0, 7));
         1:       return PRIO_W'(32'h7FFF_FFFF - $urandom_range(0, 3));
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic [ID_W-1:0] user, input logic [PRIO_W-1:0] prio);
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_kind         = kind;
      req_task_id      = id;
      req_user_id      = user;
      req_priority_req = prio;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic add_item(input logic [ID_W-1:0] id);
      known_ids.push_back(id);
      if (known_ids.size() > 128) void'(known_ids.pop_front());
      send_item(KIND_ADD, id, wide_id(), pick_prio());
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int              mode;
      logic [ID_W-1:0] id;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_ADD;
      req_task_id      = '0;
      req_user_id      = '0;
      req_priority_req = '0;
      calm             = 1'b0;
      items_sent       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(KIND_EXEC, 20'hFFFFF, 20'hFFFFF, 31'h7FFF_FFFF);
      send_item(KIND_EDIT, 20'd7, 20'd0, 31'd1);
      send_item(KIND_REMOVE, 20'd7, 20'd0, 31'd0);
      send_item(KIND_ADD, 20'd0, 20'd0, 31'd0);
      send_item(KIND_ADD, 20'hFFFFF, 20'hFFFFF, 31'h7FFF_FFFF);
      send_item(KIND_ADD, 20'd0, 20'h12345, 31'd9);
      send_item(KIND_ADD, 20'd5, 20'h00AAA, 31'h7FFF_FFFF);
      send_item(KIND_EDIT, 20'd5, 20'd0, 31'h7FFF_FFFF);
      send_item(KIND_EXEC, 20'd0, 20'd0, 31'd0);
      send_item(KIND_EXEC, 20'd0, 20'd0, 31'd0);
      send_item(KIND_EDIT, 20'd0, 20'd0, 31'd100);
      send_item(KIND_ADD, 20'd3, 20'h55555, 31'd100);
      send_item(KIND_EXEC, 20'hABCDE, 20'h54321, 31'd0);
      send_item(KIND_REMOVE, 20'd0, 20'd0, 31'd0);
      send_item(KIND_EXEC, 20'd0, 20'd0, 31'd0);
      send_item(KIND_REMOVE, 20'd0, 20'd0, 31'd0);
      hold_until_drained();

      while (items_sent < 1010) begin
         calm = (items_sent >= 920);
         mode = $urandom_range(0, 2);
         case (mode)
            0: begin
               repeat ($urandom_range(66, 72)) begin
                  case ($urandom_range(0, 9))
                     0:       id = small_id();
                     1:       id = known_id();
                     default: id = wide_id();
                  endcase
                  add_item(id);
               end
            end
            1: begin
               repeat (40) begin
                  case ($urandom_range(0, 3))
                     0: add_item($urandom_range(0, 1) ? small_id() : wide_id());
                     1: send_item(KIND_EDIT, target_id(), wide_id(), pick_prio());
                     2: send_item(KIND_REMOVE, target_id(), wide_id(), pick_prio());
                     default: send_item(KIND_EXEC, wide_id(), wide_id(), pick_prio());
                  endcase
               end
            end
            default: begin
               repeat ($urandom_range(60, 70)) begin
                  if ($urandom_range(0, 7) == 0)
                     send_item(KIND_EDIT, target_id(), wide_id(), pick_prio());
                  else
                     send_item(KIND_EXEC, wide_id(), wide_id(), pick_prio());
               end
            end
         endcase
         if ($urandom_range(0, 3) == 0) hold_until_drained();
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      $display("tb: %0d items sent across add, edit, remove and execute; %0d results checked",
               items_sent, checked);
      $display("tb: %0d full-table and %0d empty-table replies among them",
               full_seen, empty_seen);
      if (failures == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/itpt_pkg.sv
hdl/itpt_cell.sv
hdl/indexed_task_priority_table.sv
test/task_table_checker.sv
test/indexed_task_priority_table_tb.sv
